[sv/pixel_color_blend_defines.svh]
// Assertion macros shared by the pixel color blend RTL.
`ifndef PIXEL_COLOR_BLEND_DEFINES_SVH
`define PIXEL_COLOR_BLEND_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define PCB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pixel_color_blend: same-cycle check failed");

// Next-cycle implication, checked on clk outside reset.
`define PCB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pixel_color_blend: next-cycle check failed");

`endif

[sv/pcb_pkg.sv]
// Shared types, codes and arithmetic helpers of the pixel color blend.
package pcb_pkg;

    localparam int unsigned PIX_W      = 32;
    localparam int unsigned CH_W       = 8;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CH_MAX     = 255;
    localparam int unsigned ALPHA_OPAQUE = 8'hFF;
    // floor(x / 3) == (x * 683) >> 11 for every x up to 765
    localparam int unsigned GRAY_RECIP = 683;
    localparam int unsigned GRAY_SHIFT = 11;
    localparam int unsigned GSUM_W     = 10;
    localparam int unsigned GPROD_W    = 20;

    typedef enum logic [2:0] {
        MODE_XOR   = 3'd0,
        MODE_ALPHA = 3'd1,
        MODE_KEY   = 3'd2,
        MODE_GRAY  = 3'd3,
        MODE_PASS  = 3'd4
    } blend_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLEND_MODE = 8'd0,
        CFG_KEY_COLOR  = 8'd1
    } cfg_index_t;

    // Load strobes of the channel mixer stages
    typedef struct packed {
        logic s1_load;
        logic s2_load;
    } stage_en_t;

    // floor(x / 255) for x up to 255 * 255: (x + 1 + (x >> 8)) >> 8
    function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'd1 + 17'(x[15:8]);
        return t[15:8];
    endfunction

endpackage

[sv/pcb_chan_mix.sv]
// One color channel of the alpha mix: weighted products, then their sum.
module pcb_chan_mix (
    input  logic                         clk,
    input  pcb_pkg::stage_en_t           en,
    input  logic [pcb_pkg::CH_W-1:0]     src_chan,
    input  logic [pcb_pkg::CH_W-1:0]     dest_chan,
    input  logic [pcb_pkg::CH_W-1:0]     alpha,
    output logic [15:0]                  mix_sum
);

    logic [15:0] prod_src_reg;
    logic [15:0] prod_dest_reg;
    logic [15:0] prod_src_next;
    logic [15:0] prod_dest_next;
    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [pcb_pkg::CH_W-1:0] inv_alpha;

    assign inv_alpha      = pcb_pkg::CH_W'(pcb_pkg::CH_MAX) - alpha;
    assign prod_src_next  = {8'd0, src_chan} * {8'd0, alpha};
    assign prod_dest_next = {8'd0, dest_chan} * {8'd0, inv_alpha};
    // Both weights add to 255, so the sum never exceeds 255 * 255
    assign sum_next       = prod_src_reg + prod_dest_reg;

    always_ff @(posedge clk)
    begin
        if (en.s1_load)
        begin
            prod_src_reg  <= prod_src_next;
            prod_dest_reg <= prod_dest_next;
        end
        if (en.s2_load)
        begin
            sum_reg <= sum_next;
        end
    end

    assign mix_sum = sum_reg;

endmodule

[sv/pixel_color_blend.sv]
// Top level of the ARGB8888 pixel blend: stream ports, config and pipeline.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: dest_pixel, src_pixel
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: out_pixel
//  cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// Items pass through the three register stages (products, sums, divide and
// select), the last of which is the output register; one item is taken every
// cycle while m_axis is not stalled.
// An m_axis stall holds full stages with all ahead full; empty stages fill, so
// s_axis_tready drops only when all three stages hold an item.
// Reset clears the stage valid bits and sets blend_mode to alpha blend and
// key_color to zero. Config writes are always taken.
`include "pixel_color_blend_defines.svh"

module pixel_color_blend (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [63:0]                       s_axis_tdata,  // dest_pixel[31:0], src_pixel[63:32]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,  // out_pixel[31:0]
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pcb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);

    // Configuration registers
    pcb_pkg::blend_mode_t mode_reg;
    logic [31:0]          key_color_reg;

    // Stage advance chain: a stage moves when it is empty or the next moves
    logic adv1;
    logic adv2;
    logic adv3;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;

    // Stage 1 payload
    pcb_pkg::blend_mode_t           mode1_reg;
    logic [31:0]                    src1_reg;
    logic [31:0]                    dest1_reg;
    logic                           key_hit1_reg;
    logic [pcb_pkg::GSUM_W-1:0]     gsum1_reg;
    logic [pcb_pkg::GSUM_W-1:0]     gsum1_next;

    // Stage 2 payload
    pcb_pkg::blend_mode_t           mode2_reg;
    logic [31:0]                    src2_reg;
    logic [31:0]                    dest2_reg;
    logic                           key_hit2_reg;
    logic [pcb_pkg::GPROD_W-1:0]    gprod2_reg;
    logic [pcb_pkg::GPROD_W-1:0]    gprod2_next;

    // Stage 3 (output) payload
    logic [31:0]                    out_pixel_reg;
    logic [31:0]                    out_pixel_next;

    logic [31:0]      in_dest;
    logic [31:0]      in_src;
    logic [15:0]      mix_sum [3];
    logic [7:0]       mix_chan [3];
    logic [7:0]       gray;
    logic [7:0]       opaque;
    pcb_pkg::stage_en_t mix_en;

    assign in_dest = s_axis_tdata[31:0];
    assign in_src  = s_axis_tdata[63:32];

    assign adv3 = !v3_reg || m_axis_tready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign s_axis_tready = adv1;
    assign cfg_ready     = 1'b1;

    // Config writes: drop indexes beyond the register list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= pcb_pkg::MODE_ALPHA;
            key_color_reg <= 32'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pcb_pkg::CFG_BLEND_MODE: mode_reg <= pcb_pkg::blend_mode_t'(cfg_data[2:0]);
                pcb_pkg::CFG_KEY_COLOR:  key_color_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits travel with the items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= s_axis_tvalid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    // Stage 1: capture the item, compare against the key, sum source RGB
    assign gsum1_next = pcb_pkg::GSUM_W'(in_src[23:16]) + pcb_pkg::GSUM_W'(in_src[15:8])
                      + pcb_pkg::GSUM_W'(in_src[7:0]);

    always_ff @(posedge clk)
    begin
        if (adv1 && s_axis_tvalid)
        begin
            mode1_reg    <= mode_reg;
            src1_reg     <= in_src;
            dest1_reg    <= in_dest;
            key_hit1_reg <= (in_src == key_color_reg);
            gsum1_reg    <= gsum1_next;
        end
    end

    // Stage 2: scale the gray sum by the reciprocal of three
    assign gprod2_next = pcb_pkg::GPROD_W'(gsum1_reg)
                       * pcb_pkg::GPROD_W'(pcb_pkg::GRAY_RECIP);

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            mode2_reg    <= mode1_reg;
            src2_reg     <= src1_reg;
            dest2_reg    <= dest1_reg;
            key_hit2_reg <= key_hit1_reg;
            gprod2_reg   <= gprod2_next;
        end
    end

    // Channel mixers share the stage 1 and stage 2 load strobes
    assign mix_en.s1_load = adv1 && s_axis_tvalid;
    assign mix_en.s2_load = adv2 && v1_reg;

    for (genvar c = 0; c < 3; c++)
    begin : g_mix
        pcb_chan_mix u_mix (
            .clk       (clk),
            .en        (mix_en),
            .src_chan  (in_src[8*c +: 8]),
            .dest_chan (in_dest[8*c +: 8]),
            .alpha     (in_src[31:24]),
            .mix_sum   (mix_sum[c])
        );
        assign mix_chan[c] = pcb_pkg::div255(mix_sum[c]);
    end

    // Stage 3: finish the divides and pick the result by mode
    assign gray   = gprod2_reg[pcb_pkg::GRAY_SHIFT +: 8];
    assign opaque = 8'(pcb_pkg::ALPHA_OPAQUE);

    always_comb
    begin
        case (mode2_reg)
            pcb_pkg::MODE_XOR:   out_pixel_next = {opaque, dest2_reg[23:0] ^ src2_reg[23:0]};
            pcb_pkg::MODE_ALPHA: out_pixel_next = {opaque, mix_chan[2], mix_chan[1], mix_chan[0]};
            pcb_pkg::MODE_KEY:   out_pixel_next = key_hit2_reg ? dest2_reg : src2_reg;
            pcb_pkg::MODE_GRAY:  out_pixel_next = {opaque, gray, gray, gray};
            // pass source, and codes without a meaning of their own
            default:             out_pixel_next = src2_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && v2_reg)
            out_pixel_reg <= out_pixel_next;
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = out_pixel_reg;

    // A full pipeline under output stall must refuse new items
    `PCB_ASSERT_IMP(a_full_stall_blocks, v1_reg && v2_reg && v3_reg && !m_axis_tready, !s_axis_tready)
    // An accepted item occupies stage 1 on the next cycle
    `PCB_ASSERT_NXT(a_accept_fills_s1, s_axis_tvalid && s_axis_tready, v1_reg)
    // A held stage 1 keeps its item
    `PCB_ASSERT_NXT(a_s1_hold, v1_reg && !adv2, v1_reg && $stable(src1_reg) && $stable(dest1_reg))

endmodule

[dv/tb_top.sv]
// Self-checking stream testbench for the ARGB8888 pixel blend, with its own blend predictor.
module tb_top;

    // Mode codes above pass source: no meaning of their own, they pass the source
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
    localparam int         PIPE_DEPTH       = 3;
    localparam int         HOLD_CYCLES      = 200;
    localparam int         SEG_ITEMS        = 29;

    // Tracks the blend registers as written and holds the pixels still owed
    class pixel_blend_checker;
        logic [2:0]  mode;
        logic [31:0] key;
        logic [31:0] expected_pixels[$];
        int unsigned mismatches;

        function new();
            mode       = pcb_pkg::MODE_ALPHA;
            key        = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [pcb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                pcb_pkg::CFG_BLEND_MODE: mode = data[2:0];
                pcb_pkg::CFG_KEY_COLOR:  key  = data;
                default: ;
            endcase
        endfunction

        // Weighted channel mix, truncated toward zero
        function logic [7:0] mix_channel(logic [7:0] s, logic [7:0] d, logic [7:0] a);
            int unsigned num;
            num = int'(s) * int'(a) + int'(d) * (pcb_pkg::CH_MAX - int'(a));
            return 8'(num / pcb_pkg::CH_MAX);
        endfunction

        function logic [31:0] blend_pixel(logic [31:0] d, logic [31:0] s);
            int unsigned gray;
            case (mode)
                pcb_pkg::MODE_XOR:
                    return {8'(pcb_pkg::ALPHA_OPAQUE), d[23:0] ^ s[23:0]};
                pcb_pkg::MODE_ALPHA:
                    return {8'(pcb_pkg::ALPHA_OPAQUE),
                            mix_channel(s[23:16], d[23:16], s[31:24]),
                            mix_channel(s[15:8],  d[15:8],  s[31:24]),
                            mix_channel(s[7:0],   d[7:0],   s[31:24])};
                pcb_pkg::MODE_KEY:
                    return (s == key) ? d : s;
                pcb_pkg::MODE_GRAY:
                begin
                    gray = (int'(s[23:16]) + int'(s[15:8]) + int'(s[7:0])) / 3;
                    return {8'(pcb_pkg::ALPHA_OPAQUE), 8'(gray), 8'(gray), 8'(gray)};
                end
                default:
                    return s;
            endcase
        endfunction

        function void note_input(logic [31:0] d, logic [31:0] s);
            expected_pixels.push_back(blend_pixel(d, s));
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("blend check: %s, out_pixel %h, expected %h", what, got, want);
            mismatches++;
        endtask

        task check_result(logic [31:0] got);
            logic [31:0] want;
            if (expected_pixels.size() == 0)
            begin
                report("pixel out with nothing pending", got, 'x);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got !== want)
                    report("out_pixel mismatch", got, want);
            end
        endtask
    endclass

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [63:0]                   s_axis_tdata  = '0;   // dest_pixel[31:0], src_pixel[63:32]
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [31:0]                   m_axis_tdata;         // out_pixel[31:0]
    logic                          cfg_valid     = 1'b0;
    logic                          cfg_ready;
    logic [pcb_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
    logic [31:0]                   cfg_data      = '0;

    pixel_blend_checker chk = new();

    // Idle odds in percent per cycle, changed by phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    // Receiver hold-off: request raised at a rising edge, taken at the next falling edge
    bit          hold_req  = 1'b0;
    int unsigned hold_left = 0;
    logic [31:0] key_now   = '0;

    pixel_color_blend dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // Receiver: count down a hold-off in its own process, otherwise stall at random
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            m_axis_tready = 1'b0;
            hold_left--;
        end
        else
        begin
            m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: sample every handshake at the rising edge, pre-update values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                chk.write_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                chk.note_input(s_axis_tdata[31:0], s_axis_tdata[63:32]);
            if (m_axis_tvalid && m_axis_tready)
                chk.check_result(m_axis_tdata);
        end
    end

    // Offer one item; return at the falling edge after it is taken, valid still high
    task automatic push_pixel(logic [31:0] dest, logic [31:0] src);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {src, dest};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Wait until every owed pixel has come out, then let the pipe settle
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (chk.pending() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 1) @(negedge clk);
    endtask

    // Write one register while the block is idle
    task automatic cfg_write(pcb_pkg::cfg_index_t idx, logic [31:0] data);
        drain();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == pcb_pkg::CFG_KEY_COLOR)
            key_now = data;
    endtask

    // Set the mode with junk above the three mode bits
    task automatic set_mode(logic [2:0] code);
        cfg_write(pcb_pkg::CFG_BLEND_MODE, ($urandom() & ~32'h7) | 32'(code));
    endtask

    // Random pixel, now and then with channels pinned to 0x00 or 0xFF
    function automatic logic [31:0] rand_pixel();
        logic [31:0] p;
        p = $urandom();
        if ($urandom_range(0, 3) == 0)
        begin
            for (int k = 0; k < 4; k++)
            begin
                case ($urandom_range(0, 2))
                    0: p[k*8 +: 8] = 8'h00;
                    1: p[k*8 +: 8] = 8'hFF;
                    default: ;
                endcase
            end
        end
        return p;
    endfunction

    // Source pixel for the current mode: in key mode hit the key or miss by one bit often
    function automatic logic [31:0] pick_src(logic [2:0] code);
        if (code == pcb_pkg::MODE_KEY)
        begin
            case ($urandom_range(0, 5))
                0, 1: return key_now;
                2:    return key_now ^ (32'h1 << $urandom_range(0, 31));
                default: ;
            endcase
        end
        return rand_pixel();
    endfunction

    // One setting: program mode and key, then stream random items
    task automatic run_segment(logic [2:0] code, int n_items, bit pause_mid, bit squeeze);
        logic [31:0] key_val;
        case ($urandom_range(0, 5))
            0:       key_val = 32'h0000_0000;
            1:       key_val = 32'hFFFF_FFFF;
            default: key_val = $urandom();
        endcase
        set_mode(code);
        cfg_write(pcb_pkg::CFG_KEY_COLOR, key_val);
        if (squeeze)
        begin
            // Stall the receiver long enough for the pipe to fill and push back
            @(posedge clk);
            hold_req = 1'b1;
            @(negedge clk);
        end
        for (int i = 0; i < n_items; i++)
        begin
            if (pause_mid && i == n_items / 2)
                drain();
            push_pixel(rand_pixel(), pick_src(code));
        end
        s_axis_tvalid = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset values: alpha blend, key zero; alpha extremes and a midpoint
        push_pixel(32'h0000_0000, 32'hFFFF_FFFF);
        push_pixel(32'hFFFF_FFFF, 32'h0000_0000);
        push_pixel(32'h00AB_CDEF, 32'h8012_3456);
        push_pixel(32'h0000_0000, 32'h01FF_FFFF);
        push_pixel(32'hFFFF_FFFF, 32'hFE00_0000);

        // Color key against the reset key of zero
        set_mode(pcb_pkg::MODE_KEY);
        push_pixel(32'h1234_5678, 32'h0000_0000);
        push_pixel(32'h1234_5678, 32'h0000_0001);
        // Key at all ones: exact match, then alpha differing in one bit
        cfg_write(pcb_pkg::CFG_KEY_COLOR, 32'hFFFF_FFFF);
        push_pixel(32'h0000_0000, 32'hFFFF_FFFF);
        push_pixel(32'h0000_0000, 32'h7FFF_FFFF);

        set_mode(pcb_pkg::MODE_XOR);
        push_pixel(32'hFFFF_FFFF, 32'h00FF_FFFF);
        push_pixel(32'h0A5A_5A5A, 32'hF0A5_A5A5);

        // Grayscale: full white, full black, sum just divisible
        set_mode(pcb_pkg::MODE_GRAY);
        push_pixel(32'h0000_0000, 32'h00FF_FFFF);
        push_pixel(32'hFFFF_FFFF, 32'hFF00_0000);
        push_pixel(32'h1234_5678, 32'h0002_0100);

        set_mode(pcb_pkg::MODE_PASS);
        push_pixel(32'hDEAD_BEEF, 32'h0123_4567);
        set_mode(MODE_SPARE_FIRST);
        push_pixel(32'h89AB_CDEF, 32'hFEDC_BA98);
        set_mode(MODE_SPARE_LAST);
        push_pixel(32'h0000_0000, 32'h8000_0001);
        s_axis_tvalid = 1'b0;

        // Random phases: receiver-heavy idling, sender-heavy idling, then none
        for (int phase = 0; phase < 3; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    send_idle_pct = 26;
                    recv_idle_pct = 58;
                end
                1:
                begin
                    send_idle_pct = 58;
                    recv_idle_pct = 26;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 8; seg++)
                run_segment(3'(seg), SEG_ITEMS, seg == 0, phase == 2 && seg == 1);
        end

        // Collect the last pixels, then watch a while for strays
        drain();
        repeat (4 * PIPE_DEPTH) @(posedge clk);
        if (chk.mismatches == 0 && chk.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
